// ===== rtl/fst_pkg.sv =====
// Package for the fence table: payload structs, operation and result codes,
// fence state codes and the controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package fst_pkg;

	localparam logic [2:0] OP_CREATE     = 3'd0;
	localparam logic [2:0] OP_DESTROY    = 3'd1;
	localparam logic [2:0] OP_REGISTER   = 3'd2;
	localparam logic [2:0] OP_DEREGISTER = 3'd3;
	localparam logic [2:0] OP_SIGNAL     = 3'd4;

	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_INVALID   = 3'd1;
	localparam logic [2:0] RC_NO_FREE   = 3'd2;
	localparam logic [2:0] RC_ALREADY   = 3'd3;
	localparam logic [2:0] RC_NOT_FOUND = 3'd4;
	localparam logic [2:0] RC_FULL      = 3'd5;

	localparam logic [2:0] FS_UNCREATED = 3'd0;
	localparam logic [2:0] FS_CREATED   = 3'd1;
	localparam logic [2:0] FS_SIG_BASE  = 3'd2;

	localparam logic [1:0] STATUS_REJECT = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  fence_number;
		logic [1:0]  signal_status;
		logic [31:0] cause_in;
		logic [63:0] key_word_a;
		logic [63:0] key_word_b;
	} fst_in_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [5:0]  assigned_id;
		logic        event_valid;
		logic [1:0]  event_state;
		logic [31:0] evt_cause;
		logic [63:0] event_word_a;
		logic [63:0] event_word_b;
		logic        last;
	} fst_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input transaction
		logic scan_rd;    // read table entry at scan index
		logic scan_inc;   // advance scan index
		logic scan_clr;   // scan index to first
		logic wr_read;    // read waiter at walk index
		logic walk_inc;
		logic walk_clr;
		logic compact_wr; // write compacted waiter at write index
		logic wptr_inc;
		logic append_wr;  // write key at count position
		logic set_state;  // write fence state from new_state
		logic set_count;  // write count from count_src
		logic [1:0] count_src; // 0 zero, 1 plus one, 2 write index
		logic [2:0] new_state;
		logic found_set;
		logic out_load;
		logic [2:0] out_code;
		logic out_event;  // event from the read waiter (signal)
		logic out_reg_event; // event from the input key (register)
		logic out_last;
		logic out_scan_id; // assigned id from scan index
	} fst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       id_bad;
		logic       status_bad;
		logic [1:0] status;
		logic [2:0] fstate;
		logic       list_empty;
		logic       list_full;
		logic       walk_done;  // walk index reached count
		logic       walk_last;  // walk index is count - 1
		logic       key_match;  // waiter read last cycle matches the key
		logic       found;
		logic       scan_free;  // scanned entry is uncreated
		logic       scan_end;   // scan index is the last id
		logic       out_busy;
	} fst_stat_t;

endpackage

// ===== rtl/fence_sync_table.sv =====
// Fence table with ordered waiter lists. One transaction is handled at a
// time: create scans ids from 1 for the first uncreated fence, register and
// deregister walk the waiter list one entry at a time, signal emits one
// result per waiter and waits while the output is held, and other commands
// answer with a single result.
`timescale 1ns / 1ps
module fence_sync_table import fst_pkg::*; #(
	parameter int FENCES  = 64,
	parameter int WAITERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  fst_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output fst_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] cause_q;
	fst_cmd_t    cmd;
	fst_stat_t   stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cause_q <= '0;
		end else if (cfg_valid) begin
			cause_q <= cfg_data;
		end
	end

	fst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	fst_datapath #(
		.FENCES  (FENCES),
		.WAITERS (WAITERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.reg_cause (cause_q),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// ===== rtl/fst_datapath.sv =====
// Datapath of the fence table: fence state and count tables, waiter key
// memories, walk and scan counters and the output register.
// Depends on fst_pkg.
`timescale 1ns / 1ps
module fst_datapath import fst_pkg::*; #(
	parameter int FENCES  = 64,
	parameter int WAITERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fst_in_t     in_data,
	input  logic [31:0] reg_cause,
	input  fst_cmd_t    cmd,
	output fst_stat_t   stat,
	output fst_out_t    out_data,
	output logic        out_valid,
	input  logic        out_ready
);

	localparam int FW = $clog2(FENCES);
	localparam int WW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int CW = $clog2(WAITERS + 1);
	localparam int AW = $clog2(FENCES * WAITERS);

	logic [2:0]    fstate_q [FENCES];
	logic [CW-1:0] count_q  [FENCES];
	logic [63:0]   mem_a [FENCES * WAITERS];
	logic [63:0]   mem_b [FENCES * WAITERS];

	fst_in_t       in_q;
	logic [FW-1:0] fid_q;
	logic [FW-1:0] scan_q;
	logic [2:0]    scan_state_q;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] wptr_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    st_q;
	logic [63:0]   rd_a_q;
	logic [63:0]   rd_b_q;
	logic          found_q;
	logic [AW-1:0] base;
	logic [CW-1:0] new_count;
	logic [FW-1:0] wr_idx;

	always_comb begin
		base = AW'(fid_q) * AW'(WAITERS);
	end

	always_comb begin
		wr_idx = cmd.out_scan_id ? scan_q : fid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FENCES; i++) begin
				fstate_q[i] <= FS_UNCREATED;
				count_q[i]  <= '0;
			end
		end else begin
			if (cmd.set_state) begin
				fstate_q[wr_idx] <= cmd.new_state;
			end
			if (cmd.set_count) begin
				count_q[wr_idx] <= new_count;
			end
		end
	end

	always_comb begin
		unique case (cmd.count_src)
			2'd1:    new_count = cnt_q + CW'(1);
			2'd2:    new_count = wptr_q;
			default: new_count = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.append_wr) begin
			mem_a[base + AW'(cnt_q)] <= in_q.key_word_a;
			mem_b[base + AW'(cnt_q)] <= in_q.key_word_b;
		end else if (cmd.compact_wr) begin
			mem_a[base + AW'(wptr_q)] <= rd_a_q;
			mem_b[base + AW'(wptr_q)] <= rd_b_q;
		end
		if (cmd.wr_read) begin
			rd_a_q <= mem_a[base + AW'(walk_q)];
			rd_b_q <= mem_b[base + AW'(walk_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= FW'(1);
			walk_q       <= '0;
			wptr_q       <= '0;
			found_q      <= 1'b0;
			scan_state_q <= FS_UNCREATED;
		end else begin
			if (cmd.scan_clr) begin
				scan_q <= FW'(1);
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + FW'(1);
			end
			if (cmd.scan_rd) begin
				scan_state_q <= fstate_q[scan_q];
			end
			if (cmd.walk_clr) begin
				walk_q  <= '0;
				wptr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.walk_inc) begin
					walk_q <= walk_q + CW'(1);
				end
				if (cmd.wptr_inc) begin
					wptr_q <= wptr_q + CW'(1);
				end
				if (cmd.found_set) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q  <= in_data;
			fid_q <= FW'(in_data.fence_number);
			st_q  <= fstate_q[FW'(in_data.fence_number)];
			cnt_q <= count_q[FW'(in_data.fence_number)];
		end
	end

	always_comb begin
		stat.op         = in_q.op;
		stat.id_bad     = (in_q.fence_number == 6'd0) ||
			(32'(in_q.fence_number) >= 32'(FENCES));
		stat.status_bad = (in_q.signal_status == STATUS_REJECT);
		stat.status     = in_q.signal_status;
		stat.fstate     = st_q;
		stat.list_empty = (cnt_q == '0);
		stat.list_full  = (cnt_q >= CW'(WAITERS));
		stat.walk_done  = (walk_q >= cnt_q);
		stat.walk_last  = (walk_q + CW'(1) == cnt_q);
		stat.key_match  = (rd_a_q == in_q.key_word_a) && (rd_b_q == in_q.key_word_b);
		stat.found      = found_q;
		stat.scan_free  = (scan_state_q == FS_UNCREATED);
		stat.scan_end   = (32'(scan_q) == 32'(FENCES - 1));
		stat.out_busy   = out_valid && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.result_code  <= cmd.out_code;
			out_data.assigned_id  <= cmd.out_scan_id ? 6'(scan_q) :
				((in_q.op == OP_CREATE) ? 6'd0 : in_q.fence_number);
			out_data.last         <= cmd.out_last;
			out_data.event_valid  <= cmd.out_event || cmd.out_reg_event;
			out_data.event_state  <= '0;
			out_data.evt_cause    <= '0;
			out_data.event_word_a <= '0;
			out_data.event_word_b <= '0;
			if (cmd.out_event) begin
				out_data.event_state  <= in_q.signal_status;
				out_data.evt_cause    <= in_q.cause_in;
				out_data.event_word_a <= rd_a_q;
				out_data.event_word_b <= rd_b_q;
			end else if (cmd.out_reg_event) begin
				out_data.event_state  <= 2'(st_q - FS_SIG_BASE);
				out_data.evt_cause    <= reg_cause;
				out_data.event_word_a <= in_q.key_word_a;
				out_data.event_word_b <= in_q.key_word_b;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cnt_q <= CW'(WAITERS))
		else $error("waiter count beyond list size");
	a_wptr_le_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= walk_q)
		else $error("compaction write index passed read index");
	a_no_double_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.append_wr && cmd.compact_wr))
		else $error("append and compaction write together");
`endif

endmodule

// ===== rtl/fst_ctrl.sv =====
// Controller of the fence table: sequences each command over the datapath.
// Depends on fst_pkg.
`timescale 1ns / 1ps
module fst_ctrl import fst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output fst_cmd_t  cmd,
	input  fst_stat_t stat
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_SCHK   = 4'd3;
	localparam logic [3:0] S_WRD    = 4'd4;
	localparam logic [3:0] S_WCHK   = 4'd5;
	localparam logic [3:0] S_SRD    = 4'd6;
	localparam logic [3:0] S_SOUT   = 4'd7;
	localparam logic [3:0] S_RESP   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       rev_q, rev_d;
	logic       sid_q, sid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= RC_OK;
			rev_q   <= 1'b0;
			sid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			rev_q   <= rev_d;
			sid_q   <= sid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		rev_d    = rev_q;
		sid_d    = sid_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				rev_d = 1'b0;
				sid_d = 1'b0;
				cmd.walk_clr = 1'b1;
				state_d = S_RESP;
				priority if (stat.op == OP_CREATE) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else if (stat.op > OP_SIGNAL || stat.id_bad) begin
					code_d = RC_INVALID;
				end else if (stat.op == OP_SIGNAL && stat.status_bad) begin
					code_d = RC_INVALID;
				end else if (stat.fstate == FS_UNCREATED) begin
					code_d = RC_INVALID;
				end else if (stat.op == OP_DESTROY) begin
					code_d = RC_OK;
					cmd.set_state = 1'b1;
					cmd.new_state = FS_UNCREATED;
					cmd.set_count = 1'b1;
				end else if (stat.op == OP_REGISTER && stat.fstate >= FS_SIG_BASE) begin
					code_d = RC_OK;
					rev_d  = 1'b1;
				end else if (stat.op == OP_SIGNAL) begin
					if (stat.fstate != FS_CREATED) begin
						code_d = RC_ALREADY;
					end else begin
						code_d = RC_OK;
						cmd.set_state = 1'b1;
						cmd.new_state = FS_SIG_BASE + {1'b0, stat.status};
						state_d = stat.list_empty ? S_FIN : S_SRD;
					end
				end else begin
					state_d = S_WRD;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (stat.scan_free) begin
					cmd.set_state = 1'b0;
					code_d  = RC_OK;
					sid_d   = 1'b1;
					state_d = S_RESP;
				end else if (stat.scan_end) begin
					code_d  = RC_NO_FREE;
					state_d = S_RESP;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_WRD: begin
				if (stat.walk_done) begin
					if (stat.op == OP_REGISTER) begin
						if (stat.list_full) begin
							code_d = RC_FULL;
						end else begin
							code_d = RC_OK;
							cmd.append_wr = 1'b1;
							cmd.set_count = 1'b1;
							cmd.count_src = 2'd1;
						end
					end else begin
						code_d = stat.found ? RC_OK : RC_NOT_FOUND;
						cmd.set_count = 1'b1;
						cmd.count_src = 2'd2;
					end
					state_d = S_RESP;
				end else begin
					cmd.wr_read = 1'b1;
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				cmd.walk_inc = 1'b1;
				state_d = S_WRD;
				if (stat.op == OP_REGISTER) begin
					if (stat.key_match) begin
						code_d  = RC_ALREADY;
						state_d = S_RESP;
					end
				end else if (stat.key_match) begin
					cmd.found_set = 1'b1;
				end else begin
					cmd.compact_wr = 1'b1;
					cmd.wptr_inc   = 1'b1;
				end
			end
			S_SRD: begin
				if (!stat.out_busy) begin
					cmd.wr_read = 1'b1;
					state_d = S_SOUT;
				end
			end
			S_SOUT: begin
				cmd.out_load  = 1'b1;
				cmd.out_code  = RC_OK;
				cmd.out_event = 1'b1;
				cmd.out_last  = stat.walk_last;
				cmd.walk_inc  = 1'b1;
				if (stat.walk_last) begin
					cmd.set_count = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_FIN: begin
				cmd.set_count = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.out_load      = 1'b1;
					cmd.out_code      = code_q;
					cmd.out_reg_event = rev_q;
					cmd.out_scan_id   = sid_q;
					cmd.out_last      = 1'b1;
					if (sid_q) begin
						cmd.set_state = 1'b1;
						cmd.new_state = FS_CREATED;
						cmd.set_count = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("input taken outside idle");
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DECODE)
		else $error("decode does not follow a load");
	a_out_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("result overwritten while waiting");
`endif

endmodule
